### sv/sfrg_pkg.sv
// ============================================================================
// sfrg_pkg
// Shared types and constants for the static frame reuse gate.
// ============================================================================
package sfrg_pkg;

    // feature and score widths
    localparam int unsigned SHARE_W = 16;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned RISK_W  = 16;
    localparam int unsigned RUN_W   = 16;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STATIC_RUN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 1'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] MIN_STATIC_RUN_RST = 8'd3;
    localparam logic [CFG_W-1:0] REFRESH_PERIOD_RST = 8'd12;

    // static background thresholds (Q0.16)
    localparam logic [SHARE_W-1:0] TH_001 = 16'd655;
    localparam logic [SHARE_W-1:0] TH_070 = 16'd45876;
    localparam logic [SHARE_W-1:0] TH_040 = 16'd26215;
    localparam logic [SHARE_W-1:0] TH_005 = 16'd3276;
    localparam logic [SHARE_W-1:0] TH_006 = 16'd3932;
    localparam logic [SHARE_W-1:0] TH_008 = 16'd5242;
    localparam logic [SHARE_W-1:0] TH_030 = 16'd19661;

    // reciprocal scale factors, round(1024 / limit)
    localparam logic [SHARE_W-1:0] K_003 = 16'd34133;
    localparam logic [SHARE_W-1:0] K_022 = 16'd4655;
    localparam logic [SHARE_W-1:0] K_045 = 16'd2276;
    localparam logic [SHARE_W-1:0] K_005 = 16'd20480;
    localparam logic [SHARE_W-1:0] K_004 = 16'd25600;
    localparam logic [SHARE_W-1:0] K_008 = 16'd12800;
    localparam logic [SHARE_W-1:0] K_002 = 16'd51200;

    // risk floors and the low-risk limit (Q6.10)
    localparam logic [RISK_W-1:0] RISK_ONE        = 16'd1024;
    localparam logic [RISK_W-1:0] RISK_FLOOR_HIGH = 16'd2048;
    localparam logic [RISK_W-1:0] RISK_FLOOR_MID  = 16'd1536;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // frame flag bit positions
    localparam int unsigned FLAG_QUALITY = 0;
    localparam int unsigned FLAG_IDR     = 1;
    localparam int unsigned FLAG_GUARD   = 2;
    localparam int unsigned FLAG_LOW     = 3;

    // one frame request
    typedef struct packed {
        logic [SHARE_W-1:0] motion_level;
        logic [SHARE_W-1:0] cut_level;
        logic [SHARE_W-1:0] noise_level;
        logic [SHARE_W-1:0] edge_level;
        logic [SHARE_W-1:0] background_share;
        logic [SHARE_W-1:0] foreground_share;
        logic [SHARE_W-1:0] roi_share;
        logic [SHARE_W-1:0] transition_share;
        logic [SHARE_W-1:0] edge_roi_share;
        logic [SHARE_W-1:0] textured_background_share;
        logic [SHARE_W-1:0] hard_background_share;
        logic [FLAGS_W-1:0] frame_flags;
    } frame_t;

    // risk result handed to the run tracker
    typedef struct packed {
        logic [RISK_W-1:0] risk_level;
        logic              low_risk;
    } risk_t;

    // ratio v / limit as (v * k) >> 16; the largest factor keeps it below 65535
    function automatic logic [RISK_W-1:0] scale(input logic [SHARE_W-1:0] v,
                                                input logic [SHARE_W-1:0] k);
        logic [2*SHARE_W-1:0] prod;
        prod  = v * k;
        scale = prod[2*SHARE_W-1:SHARE_W];
    endfunction

    function automatic logic [RISK_W-1:0] max2(input logic [RISK_W-1:0] a,
                                               input logic [RISK_W-1:0] b);
        max2 = (a > b) ? a : b;
    endfunction

endpackage

### sv/static_frame_reuse_gate_core.sv
// ============================================================================
// static_frame_reuse_gate_core
// Per-frame reuse gate: risk score, static run tracking and reuse decision.
// ============================================================================
// Usage:
//   One request per video frame enters on the s_ group: eleven Q0.16 feature
//   shares in s_tdata and the four frame flags in s_tuser. Each request gives
//   one result on the m_ group: risk level (Q6.10), static run length and the
//   reuse candidate bit.
//   The request is captured in an input register; the risk score, the run
//   update and the decision are formed combinationally between that register
//   and the result register, which drives m_tvalid and m_tdata.
//   Throughput is one request per cycle while m_tready stays high, set by
//   the single combinational stage between the two registers.
//   When the receiver holds m_tready low the result stays in the result
//   register, one more request waits in the input register, and s_tready
//   drops until the result is taken.
//   Reset clears both stages, the run counter and the refresh phase, and loads
//   min_static_run = 3 and refresh_period = 12. Configuration is to be written
//   through cfg_we/cfg_index/cfg_wdata while idle, not enforced by the block.
// ============================================================================
module static_frame_reuse_gate_core
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [7:0]    cfg_wdata,
    // frame request
    input  logic          s_tvalid,
    output logic          s_tready,
    // motion_level, cut_level, noise_level, edge_level, background_share,
    // foreground_share, roi_share, transition_share, edge_roi_share,
    // textured_background_share, hard_background_share (16 bits each)
    input  logic [175:0]  s_tdata,
    // frame_flags
    input  logic [3:0]    s_tuser,
    // result
    output logic          m_tvalid,
    input  logic          m_tready,
    // risk_level [15:0], static_run_out [31:16], reuse_candidate [32], zero pad
    output logic [39:0]   m_tdata
);

    localparam int unsigned SW = sfrg_pkg::SHARE_W;

    logic                        in_valid_reg;
    logic [175:0]                in_data_reg;
    logic [sfrg_pkg::FLAGS_W-1:0] in_flags_reg;
    logic                        out_valid_reg;
    logic [39:0]                 out_data_reg;
    logic [39:0]                 out_data_next;
    logic [sfrg_pkg::CFG_W-1:0]  min_run_reg;
    logic [sfrg_pkg::CFG_W-1:0]  period_reg;
    logic                        advance;
    logic                        accept;
    sfrg_pkg::frame_t            frame;
    sfrg_pkg::risk_t             risk;
    logic [sfrg_pkg::RUN_W-1:0]  run_next;
    logic                        candidate;

    // pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg <= sfrg_pkg::MIN_STATIC_RUN_RST;
            period_reg  <= sfrg_pkg::REFRESH_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfrg_pkg::REG_MIN_STATIC_RUN: min_run_reg <= cfg_wdata;
                sfrg_pkg::REG_REFRESH_PERIOD: period_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg  <= s_tdata;
            in_flags_reg <= s_tuser;
        end
    end

    // unpack the request
    assign frame.motion_level              = in_data_reg[0*SW +: SW];
    assign frame.cut_level                 = in_data_reg[1*SW +: SW];
    assign frame.noise_level               = in_data_reg[2*SW +: SW];
    assign frame.edge_level                = in_data_reg[3*SW +: SW];
    assign frame.background_share          = in_data_reg[4*SW +: SW];
    assign frame.foreground_share          = in_data_reg[5*SW +: SW];
    assign frame.roi_share                 = in_data_reg[6*SW +: SW];
    assign frame.transition_share          = in_data_reg[7*SW +: SW];
    assign frame.edge_roi_share            = in_data_reg[8*SW +: SW];
    assign frame.textured_background_share = in_data_reg[9*SW +: SW];
    assign frame.hard_background_share     = in_data_reg[10*SW +: SW];
    assign frame.frame_flags               = in_flags_reg;

    sfrg_risk u_risk
    (
        .frame (frame),
        .risk  (risk)
    );

    sfrg_run u_run
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .low_risk       (risk.low_risk),
        .min_static_run (min_run_reg),
        .refresh_period (period_reg),
        .run_next       (run_next),
        .candidate      (candidate)
    );

    assign out_data_next = {7'd0, candidate, run_next, risk.risk_level};

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a candidate always has a nonzero run behind it
    a_cand_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:16] != 16'd0))
        else $error("reuse candidate with empty static run");

    // run length is nonzero exactly when the frame was low risk
    a_run_risk: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[31:16] != 16'd0) == (m_tdata[15:0] <= sfrg_pkg::RISK_ONE)))
        else $error("static run disagrees with risk level");

    // an empty input stage never refuses a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // a stalled input stage keeps its request
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled request lost");

    // a moved request always lands in the result stage
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request missing from result stage");

endmodule

### sv/sfrg_risk.sv
// ============================================================================
// sfrg_risk
// Static background test and risk score for one frame, combinational.
// ============================================================================
module sfrg_risk
(
    input  sfrg_pkg::frame_t frame,
    output sfrg_pkg::risk_t  risk
);

    localparam int unsigned NTERM = 12;

    logic                          stb;
    logic                          q_active;
    logic                          idr;
    logic                          guard;
    logic                          low_scene;
    logic [sfrg_pkg::SHARE_W-1:0]  trans_k;
    logic [sfrg_pkg::RISK_W-1:0]   term [NTERM];
    logic [sfrg_pkg::RISK_W-1:0]   lvl1 [6];
    logic [sfrg_pkg::RISK_W-1:0]   lvl2 [3];
    logic [sfrg_pkg::RISK_W-1:0]   lvl3;
    logic [sfrg_pkg::RISK_W-1:0]   peak;

    assign q_active  = frame.frame_flags[sfrg_pkg::FLAG_QUALITY];
    assign idr       = frame.frame_flags[sfrg_pkg::FLAG_IDR];
    assign guard     = frame.frame_flags[sfrg_pkg::FLAG_GUARD];
    assign low_scene = frame.frame_flags[sfrg_pkg::FLAG_LOW];

    // static textured background test
    assign stb = (frame.motion_level <= sfrg_pkg::TH_001)
              && (frame.cut_level <= sfrg_pkg::TH_001)
              && !((frame.edge_level >= sfrg_pkg::TH_070)
                   && (frame.noise_level >= sfrg_pkg::TH_040))
              && (frame.background_share >= sfrg_pkg::TH_070)
              && (frame.foreground_share <= sfrg_pkg::TH_005)
              && (frame.roi_share <= sfrg_pkg::TH_006)
              && (frame.transition_share <= sfrg_pkg::TH_008)
              && (frame.edge_roi_share <= sfrg_pkg::TH_001)
              && (frame.textured_background_share >= sfrg_pkg::TH_030);

    assign trans_k = stb ? sfrg_pkg::K_008 : sfrg_pkg::K_004;

    // ratio terms; the texture terms drop out on a static background
    always_comb
    begin
        term[0]  = sfrg_pkg::scale(frame.motion_level, sfrg_pkg::K_003);
        term[1]  = sfrg_pkg::scale(frame.cut_level, sfrg_pkg::K_003);
        term[2]  = stb ? '0 : sfrg_pkg::scale(frame.noise_level, sfrg_pkg::K_022);
        term[3]  = stb ? '0 : sfrg_pkg::scale(frame.edge_level, sfrg_pkg::K_045);
        term[4]  = stb ? '0 : sfrg_pkg::scale(frame.hard_background_share,
                                              sfrg_pkg::K_005);
        term[5]  = sfrg_pkg::scale(frame.roi_share, sfrg_pkg::K_003);
        term[6]  = sfrg_pkg::scale(frame.foreground_share, sfrg_pkg::K_005);
        term[7]  = sfrg_pkg::scale(frame.transition_share, trans_k);
        term[8]  = sfrg_pkg::scale(frame.edge_roi_share, sfrg_pkg::K_002);
        term[9]  = (q_active || idr) ? sfrg_pkg::RISK_FLOOR_HIGH : '0;
        term[10] = (guard && !stb) ? sfrg_pkg::RISK_FLOOR_HIGH : '0;
        term[11] = (!low_scene && !stb) ? sfrg_pkg::RISK_FLOOR_MID : '0;
    end

    // maximum tree
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            lvl1[i] = sfrg_pkg::max2(term[2*i], term[2*i+1]);
        end
        for (int i = 0; i < 3; i++)
        begin
            lvl2[i] = sfrg_pkg::max2(lvl1[2*i], lvl1[2*i+1]);
        end
        lvl3 = sfrg_pkg::max2(lvl2[0], lvl2[1]);
        peak = sfrg_pkg::max2(lvl3, lvl2[2]);
    end

    assign risk.risk_level = peak;
    assign risk.low_risk   = (peak <= sfrg_pkg::RISK_ONE);

endmodule

### sv/sfrg_run.sv
// ============================================================================
// sfrg_run
// Static run counter, refresh phase and reuse decision.
// ============================================================================
module sfrg_run
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         low_risk,
    input  logic [sfrg_pkg::CFG_W-1:0]   min_static_run,
    input  logic [sfrg_pkg::CFG_W-1:0]   refresh_period,
    output logic [sfrg_pkg::RUN_W-1:0]   run_next,
    output logic                         candidate
);

    logic [sfrg_pkg::RUN_W-1:0] run_reg;
    logic [sfrg_pkg::CFG_W-1:0] phase_reg;
    logic [sfrg_pkg::CFG_W-1:0] phase_next;
    logic [sfrg_pkg::CFG_W:0]   phase_inc;

    assign phase_inc = {1'b0, phase_reg} + 1'b1;

    // next run length and phase
    always_comb
    begin
        if (low_risk)
        begin
            run_next = (run_reg == sfrg_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;
            if (phase_inc >= {1'b0, refresh_period})
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[sfrg_pkg::CFG_W-1:0];
            end
        end
        else
        begin
            run_next   = '0;
            phase_next = '0;
        end
    end

    assign candidate = (run_next >= {{(sfrg_pkg::RUN_W-sfrg_pkg::CFG_W){1'b0}},
                                     min_static_run})
                    && (phase_next != '0);

    // state update once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            phase_reg <= '0;
        end
        else if (step)
        begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
        end
    end

endmodule
